FILE: src/fse_pkg.sv
`timescale 1ns / 1ps
package fse_pkg;

	// field widths fixed by the interface
	localparam int REQ_W     = 2;
	localparam int IDX_W     = 5;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_PERIOD = 2'd1;

	localparam logic [DATA_W-1:0] INV_PERIOD_RST = 32'd2670177;

	// saturation limits, Q16.16
	localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

	// quarter-wave sine polynomial, Q30
	localparam logic [63:0] POLY_A = 64'd1686629713;
	localparam logic [63:0] POLY_B = 64'd688904866;
	localparam logic [63:0] POLY_C = 64'd76016977;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PHASE,
		ST_SETUP,
		ST_EVAL,
		ST_DRAIN
	} state_t;

	// s(u) = u*(a - u^2*(b - c*u^2)), u in q30, each product truncated
	function automatic logic [30:0] quarter_sine(input logic [63:0] u);
		logic [63:0] u2;
		logic [63:0] inner;
		logic [63:0] mid;
		logic [63:0] s;
		u2    = (u * u) >> 30;
		inner = POLY_B - ((POLY_C * u2) >> 30);
		mid   = POLY_A - ((u2 * inner) >> 30);
		s     = (u * mid) >> 30;
		return s[30:0];
	endfunction

endpackage

FILE: src/fourier_series_evaluator.sv
`timescale 1ns / 1ps
// truncated fourier series evaluator, q16.16 coefficients a_i / b_i for harmonics
// 0..MAX_DEGREE. an item is taken when start is high and busy is low. a write item
// stores a coefficient pair and reports on done in the next cycle without raising
// busy; a read item raises busy for one cycle and reports in the cycle after that
// (an out-of-range read reports without raising busy); an evaluate item holds busy
// until its sum is formed and reports in the cycle after. evaluation is one term
// per cycle through a single shared 33x33 multiplier fed by the one-port coefficient
// memory and a registered quarter-wave sine rom; the phase product runs through the
// same multiplier first. every result appears on done for exactly one cycle and must
// be taken then, the receiver has no way to hold it. configuration writes are always
// accepted and must only be issued while the block is idle.
module fourier_series_evaluator
	import fse_pkg::*;
#(
	parameter int MAX_DEGREE      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        start,
	output logic                        busy,
	input  logic [REQ_W-1:0]            req_type,
	input  logic [IDX_W-1:0]            coef_index,
	input  logic signed [DATA_W-1:0]    cos_coef,
	input  logic signed [DATA_W-1:0]    sin_coef,
	input  logic signed [DATA_W-1:0]    x_value,
	// result channel
	output logic                        done,
	output logic signed [DATA_W-1:0]    value_main,
	output logic signed [DATA_W-1:0]    value_sine,
	output logic                        index_error,
	output logic                        saturated,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DATA_W-1:0]           cfg_data
);

	localparam int DEPTH  = MAX_DEGREE + 1;
	localparam int ADDR_W = $clog2(MAX_DEGREE + 1);
	localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
	// a0/2 plus two terms per harmonic, each term at most 2^31 in magnitude
	localparam int ACC_W  = 33 + $clog2(2 * MAX_DEGREE + 1);
	localparam int QTR    = 1 << (SINE_TABLE_BITS - 2);
	localparam int RA_W   = SINE_TABLE_BITS - 1;

	// configuration
	logic [IDX_W-1:0]        degree_q;
	logic [DATA_W-1:0]       inv_q;
	logic [ADDR_W-1:0]       deg_eff;
	logic [CMP_W-1:0]        deg_cmp;

	// sequencer
	state_t                  state_q, state_d;
	logic                    accept;
	logic                    idx_err;
	logic                    issue;
	logic                    mem_we;
	logic                    mem_re;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    out_load;
	logic [DATA_W-1:0]       out_main_d;
	logic [DATA_W-1:0]       out_sine_d;
	logic                    out_err_d;
	logic                    out_sat_d;

	// coefficient memory
	logic [DATA_W-1:0]       cos_mem [DEPTH];
	logic [DATA_W-1:0]       sin_mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic [DATA_W-1:0]       cos_rd_q;
	logic [DATA_W-1:0]       sin_rd_q;
	logic                    rd_vld_q;
	logic signed [DATA_W-1:0] cos_val;
	logic signed [DATA_W-1:0] sin_val;
	logic [ADDR_W-1:0]       wr_addr;

	// evaluation datapath
	logic signed [DATA_W-1:0] x_q;
	logic [DATA_W-1:0]       phase_q;
	logic [DATA_W-1:0]       ph_q;
	logic [ADDR_W-1:0]       harm_q;
	logic                    odd_q;
	logic [30:0]             qsin_rom [QTR+1];
	logic [SINE_TABLE_BITS-1:0] k_sin;
	logic [SINE_TABLE_BITS-1:0] k_sel;
	logic [SINE_TABLE_BITS-3:0] t_sel;
	logic [RA_W-1:0]         rom_addr;
	logic [30:0]             rom_s1;
	logic                    neg_s1;
	logic                    odd_s1;
	logic                    v_s1;
	logic                    v_s2;
	logic signed [DATA_W-1:0] entry_s1;
	logic signed [DATA_W-1:0] coef_s1;
	logic signed [32:0]      mul_a;
	logic signed [32:0]      mul_b;
	logic signed [65:0]      prod_q;
	logic signed [35:0]      term_w;
	logic signed [ACC_W-1:0] acc_q;
	logic                    acc_fits;
	logic [DATA_W-1:0]       sat_main;

	// result registers
	logic                    done_q;
	logic [DATA_W-1:0]       main_q;
	logic [DATA_W-1:0]       sine_q;
	logic                    err_q;
	logic                    sat_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done        = done_q;
	assign value_main  = main_q;
	assign value_sine  = sine_q;
	assign index_error = err_q;
	assign saturated   = sat_q;

	// degree above the table size acts as the table size
	assign deg_cmp = (CMP_W'(degree_q) > CMP_W'(MAX_DEGREE)) ? CMP_W'(MAX_DEGREE)
		: CMP_W'(degree_q);
	assign deg_eff = ADDR_W'(deg_cmp);
	assign idx_err = CMP_W'(coef_index) > deg_cmp;
	assign wr_addr = ADDR_W'(coef_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			inv_q    <= INV_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEGREE:     degree_q <= cfg_data[IDX_W-1:0];
				CFG_INV_PERIOD: inv_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_READ && !idx_err) begin
						state_d = ST_READ;
					end else if (req_type == REQ_EVAL) begin
						state_d = ST_PHASE;
					end
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_PHASE: state_d = ST_SETUP;
			ST_SETUP: state_d = (deg_eff == '0) ? ST_DRAIN : ST_EVAL;
			ST_EVAL: begin
				if (odd_q && harm_q == deg_eff) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		rd_addr    = '0;
		issue      = 1'b0;
		out_load   = 1'b0;
		out_main_d = '0;
		out_sine_d = '0;
		out_err_d  = 1'b0;
		out_sat_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_WRITE: begin
							out_load  = 1'b1;
							out_err_d = idx_err;
							mem_we    = !idx_err;
						end
						REQ_READ: begin
							if (idx_err) begin
								out_load  = 1'b1;
								out_err_d = 1'b1;
							end else begin
								mem_re  = 1'b1;
								rd_addr = wr_addr;
							end
						end
						REQ_EVAL: ;
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_load   = 1'b1;
				out_main_d = cos_val;
				out_sine_d = sin_val;
			end
			ST_PHASE: begin
				// a0 is fetched while the phase product forms
				mem_re  = 1'b1;
				rd_addr = '0;
			end
			ST_SETUP: ;
			ST_EVAL: begin
				issue   = 1'b1;
				mem_re  = !odd_q;
				rd_addr = harm_q;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					out_load   = 1'b1;
					out_main_d = sat_main;
					out_sat_d  = !acc_fits;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			done_q  <= out_load;
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// coefficient memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cos_mem[wr_addr] <= cos_coef;
			// sine word of the constant term is never kept
			sin_mem[wr_addr] <= (coef_index == '0) ? '0 : sin_coef;
		end
		if (mem_re) begin
			cos_rd_q <= cos_mem[rd_addr];
			sin_rd_q <= sin_mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// never-written entries read as zero
	assign cos_val = rd_vld_q ? cos_rd_q : '0;
	assign sin_val = rd_vld_q ? sin_rd_q : '0;

	// quarter-wave table, entries 0..QTR inclusive so the mirrored quadrant reaches 1.0
	for (genvar g = 0; g <= QTR; g++) begin : g_rom
		assign qsin_rom[g] = quarter_sine(64'(g) << (32 - SINE_TABLE_BITS));
	end

	// even slot is the cosine term, shifted a quarter turn
	assign k_sin    = ph_q[31 -: SINE_TABLE_BITS];
	assign k_sel    = odd_q ? k_sin : k_sin + SINE_TABLE_BITS'(QTR);
	assign t_sel    = k_sel[SINE_TABLE_BITS-3:0];
	assign rom_addr = k_sel[SINE_TABLE_BITS-2] ? RA_W'(QTR) - RA_W'(t_sel) : RA_W'(t_sel);

	assign entry_s1 = neg_s1 ? -DATA_W'({1'b0, rom_s1}) : DATA_W'({1'b0, rom_s1});
	assign coef_s1  = odd_s1 ? sin_val : cos_val;

	// shared multiplier: phase product first, then one term per cycle
	always_comb begin
		if (state_q == ST_PHASE) begin
			mul_a = {x_q[DATA_W-1], x_q};
			mul_b = {1'b0, inv_q};
		end else begin
			mul_a = {coef_s1[DATA_W-1], coef_s1};
			mul_b = {entry_s1[DATA_W-1], entry_s1};
		end
	end

	// floor of the product over 2^30
	assign term_w = prod_q[65:30];

	assign acc_fits = acc_q[ACC_W-1:31] == {(ACC_W - 31){acc_q[ACC_W-1]}};
	assign sat_main = acc_fits ? acc_q[31:0] : (acc_q[ACC_W-1] ? Q_MIN : Q_MAX);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_value;
		end
		rom_s1 <= qsin_rom[rom_addr];
		neg_s1 <= k_sel[SINE_TABLE_BITS-1];
		odd_s1 <= odd_q;
		prod_q <= mul_a * mul_b;
		if (state_q == ST_SETUP) begin
			// phase in turns is bits 39..8 of the q24.40 product
			phase_q <= prod_q[39:8];
			ph_q    <= prod_q[39:8];
			harm_q  <= ADDR_W'(1);
			odd_q   <= 1'b0;
			acc_q   <= ACC_W'(cos_val >>> 1);
		end else begin
			if (issue) begin
				odd_q <= !odd_q;
				if (odd_q) begin
					ph_q   <= ph_q + phase_q;
					harm_q <= harm_q + ADDR_W'(1);
				end
			end
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(term_w);
			end
		end
		if (out_load) begin
			main_q <= out_main_d;
			sine_q <= out_sine_d;
			err_q  <= out_err_d;
			sat_q  <= out_sat_d;
		end
	end

	// results only come out while the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_err_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(index_error && saturated))
		else $error("index error and saturation together");

	a_sine_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && value_sine != '0) |-> $past(state_q == ST_READ))
		else $error("sine word outside a read result");

	a_harm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (harm_q != '0 && harm_q <= deg_eff))
		else $error("harmonic counter out of range");

	a_acc_window: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_EVAL || state_q == ST_DRAIN))
		else $error("term accumulated outside evaluation");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import fse_pkg::*;

	// request code the block does not define, and register slots with nothing behind them
	localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

	localparam int TOP_HARMONIC = 16;
	// covers the longest evaluate's busy time plus its report, with margin
	localparam int DRAIN_CYCLES = 45;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 65;

	// quarter-wave polynomial coefficients, q30
	localparam longint unsigned SIN_A   = 64'd1686629713;
	localparam longint unsigned SIN_B   = 64'd688904866;
	localparam longint unsigned SIN_C   = 64'd76016977;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic [DATA_W-1:0] main;
		logic [DATA_W-1:0] sine;
		logic              err;
		logic              sat;
	} series_result_t;

	// one line of the directed table: either a register write or an item
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [DATA_W-1:0]    reg_val;
		logic [REQ_W-1:0]     rq;
		logic [IDX_W-1:0]     ix;
		logic [DATA_W-1:0]    cc;
		logic [DATA_W-1:0]    sc;
		logic [DATA_W-1:0]    xv;
		bit                   typed;
		series_result_t       want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [REQ_W-1:0]     req_type = '0;
	logic [IDX_W-1:0]     coef_index = '0;
	logic [DATA_W-1:0]    cos_coef = '0;
	logic [DATA_W-1:0]    sin_coef = '0;
	logic [DATA_W-1:0]    x_value = '0;
	logic                 done;
	logic [DATA_W-1:0]    value_main;
	logic [DATA_W-1:0]    value_sine;
	logic                 index_error;
	logic                 saturated;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	// predictor copy of the coefficient tables and the two registers
	logic [DATA_W-1:0] cos_store [0:TOP_HARMONIC];
	logic [DATA_W-1:0] sin_store [0:TOP_HARMONIC];
	logic [4:0]        deg_reg;
	logic [DATA_W-1:0] inv_reg;

	series_result_t pending_results [$];
	series_result_t oldest;
	stim_row_t      directed_rows [$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned results_seen = 0;
	int unsigned n_write = 0;
	int unsigned n_read = 0;
	int unsigned n_eval = 0;
	int unsigned n_unused = 0;
	int unsigned n_sat_seen = 0;
	int unsigned n_err_seen = 0;
	int unsigned n_reg_writes = 0;

	fourier_series_evaluator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.coef_index  (coef_index),
		.cos_coef    (cos_coef),
		.sin_coef    (sin_coef),
		.x_value     (x_value),
		.done        (done),
		.value_main  (value_main),
		.value_sine  (value_sine),
		.index_error (index_error),
		.saturated   (saturated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// s(u) = u*(a - u^2*(b - c*u^2)) on a q30 quarter turn, every product truncated
	function automatic longint quarter_wave(input longint unsigned u);
		longint unsigned sq;
		longint unsigned inr;
		longint unsigned mid;
		sq  = (u * u) >> 30;
		inr = SIN_B - ((SIN_C * sq) >> 30);
		mid = SIN_A - ((sq * inr) >> 30);
		return longint'((u * mid) >> 30);
	endfunction

	// 1024-entry q2.30 sine table: top two bits pick the quadrant, the rest the position in it
	function automatic longint wave_sample(input logic [9:0] k);
		longint unsigned frac;
		longint          mag;
		frac = longint'(k[7:0]) << 22;
		mag  = k[8] ? quarter_wave(ONE_Q30 - frac) : quarter_wave(frac);
		return k[9] ? -mag : mag;
	endfunction

	// a degree register above the table size behaves as the table size
	function automatic logic [4:0] active_degree();
		return (deg_reg > 5'(TOP_HARMONIC)) ? 5'(TOP_HARMONIC) : deg_reg;
	endfunction

	// expected result of one item, updating the predicted tables on a write
	function automatic series_result_t apply_request(input logic [REQ_W-1:0] rq,
		input logic [IDX_W-1:0] ix, input logic [DATA_W-1:0] cc, input logic [DATA_W-1:0] sc,
		input logic [DATA_W-1:0] xv);
		series_result_t res;
		logic [4:0]     top;
		longint         acc;
		longint         xs;
		longint         ip;
		logic [63:0]    pw;
		logic [31:0]    turn;
		logic [31:0]    hturn;
		logic [31:0]    hn;
		logic [9:0]     k;
		int             h;
		res = '0;
		top = active_degree();
		case (rq) inside
		REQ_WRITE, REQ_READ: begin
			if (ix > top) begin
				res.err = 1'b1;
			end else if (rq == REQ_WRITE) begin
				cos_store[ix] = cc;
				// the sine word of the constant term does not exist
				sin_store[ix] = (ix == 0) ? '0 : sc;
			end else begin
				res.main = cos_store[ix];
				res.sine = (ix == 0) ? '0 : sin_store[ix];
			end
		end
		REQ_EVAL: begin
			// phase in turns: bits 39..8 of the exact signed product, wraps for negative x
			xs   = longint'($signed(xv));
			ip   = longint'({32'd0, inv_reg});
			pw   = xs * ip;
			turn = pw[39:8];
			acc  = longint'($signed(cos_store[0])) >>> 1;
			for (h = 1; h <= top; h++) begin
				hn    = h;
				hturn = turn * hn;
				k     = hturn[31:22];
				acc += (longint'($signed(cos_store[h])) * wave_sample(k + 10'd256)) >>> 30;
				acc += (longint'($signed(sin_store[h])) * wave_sample(k)) >>> 30;
			end
			if (acc > 64'sd2147483647) begin
				acc     = 64'sd2147483647;
				res.sat = 1'b1;
			end else if (acc < -64'sd2147483648) begin
				acc     = -64'sd2147483648;
				res.sat = 1'b1;
			end
			res.main = acc[31:0];
		end
		default: ;
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------- result checking

	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s wrong, expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// results cannot be held off, so every done cycle is taken as it comes
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (saturated === 1'b1) n_sat_seen++;
			if (index_error === 1'b1) n_err_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with nothing outstanding, main %h sine %h", $time,
					value_main, value_sine);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("value_main", oldest.main, value_main);
				check_field("value_sine", oldest.sine, value_sine);
				check_field("index_error", 32'(oldest.err), 32'(index_error));
				check_field("saturated", 32'(oldest.sat), 32'(saturated));
			end
		end
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results outstanding", $time, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [DATA_W-1:0] rand_word();
		logic [19:0] r;
		case ($urandom_range(0, 9))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0;
		3, 4, 5: begin
			// small values keep most sums inside the 32-bit range
			r = 20'($urandom);
			return {{12{r[19]}}, r};
		end
		default: return $urandom;
		endcase
	endfunction

	// mostly back-to-back, sometimes a short gap, rarely a long one
	function automatic int pick_gap(input bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void row_item(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] ix,
		input logic [DATA_W-1:0] cc, input logic [DATA_W-1:0] sc, input logic [DATA_W-1:0] xv,
		input bit typed = 1'b0, input logic [DATA_W-1:0] wm = '0,
		input logic [DATA_W-1:0] ws = '0, input logic we = 1'b0);
		stim_row_t r;
		r = '{default: '0};
		r.rq = rq;
		r.ix = ix;
		r.cc = cc;
		r.sc = sc;
		r.xv = xv;
		r.typed = typed;
		r.want = {wm, ws, we, 1'b0};
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic void row_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [DATA_W-1:0] val);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg  = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// present one item and hold it until the block takes it; start stays high on return
	task automatic run_item(input logic [REQ_W-1:0] rq, input logic [IDX_W-1:0] ix,
		input logic [DATA_W-1:0] cc, input logic [DATA_W-1:0] sc, input logic [DATA_W-1:0] xv,
		input bit typed, input series_result_t want);
		series_result_t pred;
		start      <= 1'b1;
		req_type   <= rq;
		coef_index <= ix;
		cos_coef   <= cc;
		sin_coef   <= sc;
		x_value    <= xv;
		do @(posedge clk); while (busy !== 1'b0);
		// taken at this edge: predict now, before anything else can touch the tables
		pred = apply_request(rq, ix, cc, sc, xv);
		pending_results.insert(pending_results.size(), typed ? want : pred);
		case (rq)
		REQ_WRITE: n_write++;
		REQ_READ:  n_read++;
		REQ_EVAL:  n_eval++;
		default:   n_unused++;
		endcase
	endtask

	// idle the item channel for the given gap with junk on the payload
	task automatic hold_off(input int n);
		if (n > 0) begin
			start      <= 1'b0;
			req_type   <= REQ_W'($urandom);
			coef_index <= IDX_W'($urandom);
			cos_coef   <= $urandom;
			sin_coef   <= $urandom;
			x_value    <= $urandom;
			cfg_index  <= CFG_IDX_W'($urandom);
			cfg_data   <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending, let every outstanding result arrive, then let the block settle
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register writes only ever happen with the block idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [DATA_W-1:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (sel)
		CFG_DEGREE:     deg_reg = val[4:0];
		CFG_INV_PERIOD: inv_reg = val;
		default: ;
		endcase
		n_reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		logic [REQ_W-1:0] rq;
		logic [IDX_W-1:0] ix;
		int               r;
		r  = $urandom_range(0, 99);
		rq = (r < 30) ? REQ_WRITE : (r < 55) ? REQ_READ : (r < 95) ? REQ_EVAL : REQ_UNUSED;
		// mostly indexes near the live range, some anywhere in the field
		if ($urandom_range(0, 3) == 0)
			ix = IDX_W'($urandom_range(0, 31));
		else
			ix = IDX_W'($urandom_range(0, int'(active_degree()) + 1));
		run_item(rq, ix, rand_word(), rand_word(), rand_word(), 1'b0, '0);
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		int             p;
		int             n;
		logic [31:0]    deg_word;
		logic [31:0]    inv_word;
		bit             steady;

		deg_reg = '0;
		inv_reg = INV_PERIOD_RST;
		for (n = 0; n <= TOP_HARMONIC; n++) begin
			cos_store[n] = '0;
			sin_store[n] = '0;
		end

		// directed table; typed expectations only where they are obvious
		// state right after reset: degree zero, tables clear
		row_item(REQ_READ, 5'd0, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_READ, 5'd1, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		row_item(REQ_WRITE, 5'd1, 32'h5, 32'h5, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		row_item(REQ_UNUSED, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h0, 1'b1, 32'h0, 32'h0, 1'b0);
		// sine word of the constant term is thrown away
		row_item(REQ_WRITE, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_READ, 5'd0, '0, '0, '0, 1'b1, 32'h8000_0000, 32'h0, 1'b0);
		// degree zero: the sum is just half the constant term
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h7FFF_FFFF, 1'b1, 32'hC000_0000, 32'h0, 1'b0);
		// full table, fastest period
		row_cfg(CFG_DEGREE, 32'd16);
		row_cfg(CFG_INV_PERIOD, 32'hFFFF_FFFF);
		row_item(REQ_WRITE, 5'd16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_WRITE, 5'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_WRITE, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_WRITE, 5'd0, 32'h7FFF_FFFF, 32'h0, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_READ, 5'd16, '0, '0, '0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		row_item(REQ_READ, 5'd17, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		row_item(REQ_READ, 5'd31, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h0);
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h8000_0000);
		row_item(REQ_WRITE, 5'd31, 32'h1234_5678, 32'h1234_5678, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		// degree register past the table behaves as the table size; zero inverse period
		row_cfg(CFG_DEGREE, 32'd31);
		row_cfg(CFG_INV_PERIOD, 32'h0);
		row_item(REQ_READ, 5'd16, '0, '0, '0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		row_item(REQ_READ, 5'd17, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b1);
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h7FFF_FFFF);
		// unknown register slots are dropped; upper degree bits are masked off
		row_cfg(CFG_SPARE2, 32'hFFFF_FFFF);
		row_cfg(CFG_SPARE3, 32'h1234_5678);
		row_cfg(CFG_DEGREE, 32'hFFFF_FFE2);
		row_cfg(CFG_INV_PERIOD, 32'h0100_0000);
		// quarter turn, then the most negative coefficients at a negative point
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'h0000_4000);
		row_item(REQ_WRITE, 5'd1, 32'h8000_0000, 32'h8000_0000, '0, 1'b1, 32'h0, 32'h0, 1'b0);
		row_item(REQ_EVAL, 5'd0, '0, '0, 32'hFFFF_C000);
		row_item(REQ_READ, 5'd3, '0, '0, '0, 1'b1, 32'h0, 32'h0, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_register(directed_rows[i].reg_sel, directed_rows[i].reg_val);
			end else begin
				run_item(directed_rows[i].rq, directed_rows[i].ix, directed_rows[i].cc,
					directed_rows[i].sc, directed_rows[i].xv, directed_rows[i].typed,
					directed_rows[i].want);
				hold_off(pick_gap(1'b0));
			end
		end

		// random phases, each under its own register setting
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
			0: begin deg_word = 32'd16; inv_word = INV_PERIOD_RST; end
			1: begin
				deg_word = {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd31};
				inv_word = 32'hFFFF_FFFF;
			end
			2: begin deg_word = 32'd0; inv_word = 32'h0; end
			3: begin deg_word = 32'd1; inv_word = 32'h0100_0000; end
			4: begin deg_word = 32'd8; inv_word = $urandom; end
			default: begin deg_word = $urandom; inv_word = $urandom; end
			endcase
			write_register(CFG_DEGREE, deg_word);
			write_register(CFG_INV_PERIOD, inv_word);
			// every third phase runs flat out with no gaps
			steady = (p % 3 == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_item();
				// halfway through, wait for the block to empty completely
				if (n == PHASE_ITEMS / 2)
					drain_results();
				else
					hold_off(pick_gap(steady));
			end
		end

		drain_results();

		$display("covered %0d writes, %0d reads, %0d evaluates, %0d unused-code items",
			n_write, n_read, n_eval, n_unused);
		$display("%0d results checked (%0d clipped, %0d index errors), %0d register writes",
			results_seen, n_sat_seen, n_err_seen, n_reg_writes);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
